### rtl/pcapdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcapdf_pkg
// Shared types and constants for the pcap record deframer.
// ----------------------------------------------------------------------------
package pcapdf_pkg;

	// Stream framing constants.
	localparam int unsigned GLOBAL_HDR_BYTES = 24;
	localparam int unsigned RECORD_HDR_BYTES = 16;
	localparam int unsigned LEN_BYTE_FIRST   = 8;
	localparam int unsigned LEN_BYTE_LAST    = 11;

	// Register and field sizes.
	localparam int unsigned LEN_W          = 16;
	localparam int unsigned HDR_CNT_W      = 5;
	localparam int unsigned KEPT_LEN_W     = 7;
	localparam int unsigned KEPT_LEN_MAX   = 127;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

	// Default peek window in bytes.
	localparam int unsigned PEEK_MAX_DEF = 64;

	// Parsing phase.
	typedef enum logic [1:0] {
		PH_GLOBAL = 2'd0,
		PH_RECORD = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [7:0]            data;
		logic                  byte_valid;
		logic                  frame_end;
		logic [KEPT_LEN_W-1:0] kept_length;
	} result_t;

endpackage

### rtl/pcap_record_deframer_top.sv
`timescale 1ns / 1ps
// Each result item is registered in the output register, or in the skid register.
// Throughput: one input item per cycle; the per-byte parser is a single registered pass.
// A two-entry output (result register plus skid register) lets input continue while
// a result waits; input stalls only while the skid register is full.
// Reset (arst_n low, asynchronous) returns the parser to the global header and sets
// the length limit to 4096.
// ----------------------------------------------------------------------------
// pcap_record_deframer_top
// Skips the pcap global header, reads each record header's included length and
// emits the first PEEK_MAX body bytes of each record, closing it with a frame end.
// ----------------------------------------------------------------------------
module pcap_record_deframer_top #(
	parameter int unsigned PEEK_MAX = pcapdf_pkg::PEEK_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration
	input  logic                              cfg_wr_en,
	input  logic [pcapdf_pkg::LEN_W-1:0]      cfg_wr_data,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        in_byte,
	// Output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        out_byte,
	output logic                              byte_valid,
	output logic                              frame_end,
	output logic [pcapdf_pkg::KEPT_LEN_W-1:0] kept_length
);

	localparam int unsigned KW = $clog2(PEEK_MAX + 1);
	localparam int unsigned LW = pcapdf_pkg::LEN_W;
	localparam int unsigned HW = pcapdf_pkg::HDR_CNT_W;

	// Parser state.
	pcapdf_pkg::phase_t phase_q, phase_d;
	logic [HW-1:0] hcnt_q, hcnt_d;
	logic [LW-1:0] len_lo_q, len_lo_d;
	logic          len_hi_nz_q, len_hi_nz_d;
	logic [LW-1:0] body_len_q, body_len_d;
	logic [LW-1:0] seen_q, seen_d;
	logic [KW-1:0] kept_q, kept_d;
	logic [LW-1:0] max_len_q;

	// Output staging.
	pcapdf_pkg::result_t res_d, out_q, skid_q;
	logic res_valid_d;
	logic out_valid_q, skid_valid_q;

	logic accept;
	logic out_free;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= pcapdf_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// Per-byte parse: next state and result for the item at the input.
	always_comb begin
		logic          keep;
		logic [KW-1:0] kept_n;
		logic [LW-1:0] seen_n;
		logic [LW-1:0] blen;

		keep        = 1'b0;
		kept_n      = kept_q;
		seen_n      = seen_q;
		blen        = '0;
		phase_d     = phase_q;
		hcnt_d      = hcnt_q;
		len_lo_d    = len_lo_q;
		len_hi_nz_d = len_hi_nz_q;
		body_len_d  = body_len_q;
		seen_d      = seen_q;
		kept_d      = kept_q;
		res_valid_d = 1'b0;
		res_d       = '0;

		case (phase_q)
			pcapdf_pkg::PH_RECORD: begin
				// Collect the little-endian included length from header bytes 8 to 11.
				if (hcnt_q == HW'(pcapdf_pkg::LEN_BYTE_FIRST)) begin
					len_lo_d[7:0] = in_byte;
				end else if (hcnt_q == HW'(pcapdf_pkg::LEN_BYTE_FIRST + 1)) begin
					len_lo_d[15:8] = in_byte;
				end else if (hcnt_q >= HW'(pcapdf_pkg::LEN_BYTE_FIRST + 2) &&
					hcnt_q <= HW'(pcapdf_pkg::LEN_BYTE_LAST)) begin
					len_hi_nz_d = len_hi_nz_q || (in_byte != 8'd0);
				end
				hcnt_d = hcnt_q + HW'(1);
				if (hcnt_q == HW'(pcapdf_pkg::RECORD_HDR_BYTES - 1)) begin
					// Header complete: an oversized length counts as zero.
					if (!len_hi_nz_q && (len_lo_q <= max_len_q)) begin
						blen = len_lo_q;
					end
					hcnt_d      = '0;
					seen_d      = '0;
					kept_d      = '0;
					body_len_d  = blen;
					len_lo_d    = '0;
					len_hi_nz_d = 1'b0;
					if (blen == '0) begin
						res_valid_d     = 1'b1;
						res_d.frame_end = 1'b1;
					end else begin
						phase_d = pcapdf_pkg::PH_BODY;
					end
				end
			end
			pcapdf_pkg::PH_BODY: begin
				// Keep the byte while inside the peek window, count it either way.
				keep   = 32'(kept_q) < PEEK_MAX;
				kept_n = kept_q + KW'(keep);
				seen_n = seen_q + LW'(1);
				kept_d = kept_n;
				seen_d = seen_n;
				if (keep) begin
					res_d.data       = in_byte;
					res_d.byte_valid = 1'b1;
					res_valid_d      = 1'b1;
				end
				if (seen_n >= body_len_q) begin
					phase_d           = pcapdf_pkg::PH_RECORD;
					hcnt_d            = '0;
					len_lo_d          = '0;
					len_hi_nz_d       = 1'b0;
					res_valid_d       = 1'b1;
					res_d.frame_end   = 1'b1;
					res_d.kept_length = (32'(kept_n) > pcapdf_pkg::KEPT_LEN_MAX) ?
						pcapdf_pkg::KEPT_LEN_W'(pcapdf_pkg::KEPT_LEN_MAX) :
						pcapdf_pkg::KEPT_LEN_W'(kept_n);
				end
			end
			default: begin
				// Global header is skipped byte by byte.
				hcnt_d = hcnt_q + HW'(1);
				if (hcnt_q == HW'(pcapdf_pkg::GLOBAL_HDR_BYTES - 1)) begin
					hcnt_d      = '0;
					len_lo_d    = '0;
					len_hi_nz_d = 1'b0;
					phase_d     = pcapdf_pkg::PH_RECORD;
				end
			end
		endcase
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pcapdf_pkg::PH_GLOBAL;
			hcnt_q      <= '0;
			len_lo_q    <= '0;
			len_hi_nz_q <= 1'b0;
			body_len_q  <= '0;
			seen_q      <= '0;
			kept_q      <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			hcnt_q      <= hcnt_d;
			len_lo_q    <= len_lo_d;
			len_hi_nz_q <= len_hi_nz_d;
			body_len_q  <= body_len_d;
			seen_q      <= seen_d;
			kept_q      <= kept_d;
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_valid_d;
			end
		end else if (accept && res_valid_d) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload of the output and skid entries.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept && res_valid_d) begin
				out_q <= res_d;
			end
		end else if (accept && res_valid_d) begin
			skid_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_q.data;
	assign byte_valid  = out_q.byte_valid;
	assign frame_end   = out_q.frame_end;
	assign kept_length = out_q.kept_length;

	// The skid entry is only ever occupied behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while the output register is empty");

	// The skid entry only fills while the output is stalled.
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_stall))
		else $error("skid entry filled without a stalled output");

	// A kept length is reported only with a frame end.
	a_kept_len_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_end) |-> (kept_length == '0))
		else $error("kept length reported on an item without frame end");

	// A dropped or absent body byte always reads as zero.
	a_byte_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (out_byte == 8'd0))
		else $error("out_byte nonzero without byte_valid");

endmodule
